[hw/rtl/csw_pkg.sv]
// Shared codes and widths for the counting semaphore with a wait list.
`default_nettype none

package csw_pkg;

    // Fixed field widths.
    localparam int unsigned CountW  = 8;
    localparam int unsigned TidW    = 3;
    localparam int unsigned StatusW = 3;
    localparam int unsigned CfgIdxW = 2;

    typedef logic [StatusW-1:0] t_status;
    typedef logic [CountW-1:0]  t_count;
    typedef logic [TidW-1:0]    t_tid;

    // Request kinds.
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes.
    localparam t_status ST_GRANTED  = 3'd0;
    localparam t_status ST_BLOCKED  = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_RELEASED = 3'd3;
    localparam t_status ST_IGNORED  = 3'd4;
    localparam t_status ST_WOKEN    = 3'd5;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_MAX_COUNT     = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_INITIAL_COUNT = 2'd1;

endpackage

`default_nettype wire

[hw/rtl/counting_semaphore_wait_list.sv]
// Counting semaphore with a last-in first-out list of blocked threads.
//
//   Channel  | Dir | Signals                        | Beat contents (lowest bit up)
//   ---------+-----+--------------------------------+-----------------------------------
//   request  | in  | s_tvalid/s_tready/s_tdata/user | tuser: command; tdata: thread_id
//   result   | out | m_tvalid/m_tready/m_tdata/user | tuser: status; tdata: woken_thread,
//            |     | /m_tlast                       |   count_now; tlast: last
//   config   | in  | i_cfg_we/i_cfg_idx/i_cfg_data  | register index, 8-bit value
//
// An acquire or an ignored release yields a single result beat. A release that
// wakes waiters yields the release beat and then one beat per waiter: the wait
// list sits in a one-port-write, one-port-read memory and each waiter is one
// registered read, overlapped with the emission of the previous result.
// Reset (synchronous, active low) empties the list and loads the count; the
// list memory needs no clearing pass. A stalled result holds the block: a
// new request is taken only when the output register is empty or drains.
`default_nettype none

module counting_semaphore_wait_list #(
    parameter int unsigned NUM_THREADS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Request stream.
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,   // [2:0] thread_id, [7:3] zero
    input  wire                              s_tuser,   // [0] command
    // Result stream.
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [15:0]                      m_tdata,   // [2:0] woken_thread, [10:3] count_now
    output logic [2:0]                       m_tuser,   // [2:0] status
    output logic                             m_tlast,
    // Configuration writes.
    input  wire                              i_cfg_we,
    input  wire  [csw_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  wire  [csw_pkg::CountW-1:0]       i_cfg_data
);

    localparam int unsigned AddrW  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int unsigned TotalW = $clog2(NUM_THREADS + 1);

    // Controller states.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAKE = 1'b1;

    logic                  r_state, n_state;
    csw_pkg::t_count       r_max, n_max;
    csw_pkg::t_count       r_init, n_init;
    csw_pkg::t_count       r_count, n_count;
    logic [TotalW-1:0]     r_total, n_total;

    logic                  r_m_tvalid, n_m_tvalid;
    csw_pkg::t_status      r_status, n_status;
    csw_pkg::t_tid         r_tid_out, n_tid_out;
    csw_pkg::t_count       r_count_out, n_count_out;
    logic                  r_last, n_last;

    // Wait list memory.
    csw_pkg::t_tid         r_stack [NUM_THREADS];
    csw_pkg::t_tid         r_rd_data;
    logic                  w_wr_en;
    logic [AddrW-1:0]      w_wr_addr;
    logic                  w_rd_en;
    logic [AddrW-1:0]      w_rd_addr;

    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_cfg_hit;
    csw_pkg::t_tid         w_tid_in;
    logic [TotalW-1:0]     w_total_dec;

    assign w_out_free  = !r_m_tvalid || m_tready;
    assign s_tready    = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = s_tvalid && s_tready;
    assign w_tid_in    = s_tdata[csw_pkg::TidW-1:0];
    assign w_total_dec = r_total - TotalW'(1);
    assign w_cfg_hit   = i_cfg_we && ((i_cfg_idx == csw_pkg::REG_MAX_COUNT) ||
                                      (i_cfg_idx == csw_pkg::REG_INITIAL_COUNT));

    // Request handling, wake sequencing and configuration.
    always_comb begin
        n_state     = r_state;
        n_max       = r_max;
        n_init      = r_init;
        n_count     = r_count;
        n_total     = r_total;
        n_m_tvalid  = r_m_tvalid && !m_tready;
        n_status    = r_status;
        n_tid_out   = r_tid_out;
        n_count_out = r_count_out;
        n_last      = r_last;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_total[AddrW-1:0];
        w_rd_en     = 1'b0;
        w_rd_addr   = w_total_dec[AddrW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_m_tvalid = 1'b1;
                    n_tid_out  = '0;
                    n_last     = 1'b1;
                    if (s_tuser == csw_pkg::CMD_ACQUIRE) begin
                        if (r_count != '0) begin
                            n_count  = r_count - csw_pkg::CountW'(1);
                            n_status = csw_pkg::ST_GRANTED;
                        end else if (r_total == TotalW'(NUM_THREADS)) begin
                            n_status = csw_pkg::ST_FULL;
                        end else begin
                            w_wr_en   = 1'b1;
                            n_total   = r_total + TotalW'(1);
                            n_status  = csw_pkg::ST_BLOCKED;
                            n_tid_out = w_tid_in;
                        end
                    end else if (r_count >= r_max) begin
                        n_status = csw_pkg::ST_IGNORED;
                    end else begin
                        n_count  = r_count + csw_pkg::CountW'(1);
                        n_status = csw_pkg::ST_RELEASED;
                        if (r_total != '0) begin
                            // Fetch the top waiter while the release beat goes out.
                            n_last  = 1'b0;
                            w_rd_en = 1'b1;
                            n_total = w_total_dec;
                            n_state = S_WAKE;
                        end
                    end
                    n_count_out = n_count;
                end
            end
            S_WAKE: begin
                // Emit the fetched waiter and fetch the next one in the same cycle.
                if (w_out_free) begin
                    n_m_tvalid  = 1'b1;
                    n_status    = csw_pkg::ST_WOKEN;
                    n_tid_out   = r_rd_data;
                    n_count_out = r_count;
                    n_last      = (r_total == '0);
                    if (r_total == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        w_rd_en = 1'b1;
                        n_total = w_total_dec;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A register write repeats the set-up: reload the count, empty the list.
        if (w_cfg_hit) begin
            if (i_cfg_idx == csw_pkg::REG_MAX_COUNT) begin
                n_max = (i_cfg_data == '0) ? csw_pkg::CountW'(1) : i_cfg_data;
            end else begin
                n_init = i_cfg_data;
            end
            n_count = (n_init > n_max) ? n_max : n_init;
            n_total = '0;
        end
    end

    // Control and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_max      <= csw_pkg::CountW'(1);
            r_init     <= '0;
            r_count    <= '0;
            r_total    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_max      <= n_max;
            r_init     <= n_init;
            r_count    <= n_count;
            r_total    <= n_total;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_tid_out   <= n_tid_out;
        r_count_out <= n_count_out;
        r_last      <= n_last;
    end

    // Wait list memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[w_wr_addr] <= w_tid_in;
        end
        if (w_rd_en) begin
            r_rd_data <= r_stack[w_rd_addr];
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tuser  = r_status;
    assign m_tdata  = {5'd0, r_count_out, r_tid_out};
    assign m_tlast  = r_last;

endmodule

`default_nettype wire

[hw/rtl/csw_checker.sv]
// Port-level checks for the counting semaphore, bound to its top level.
`default_nettype none

module csw_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [7:0]  s_tdata,
    input  wire        s_tuser,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [15:0] m_tdata,
    input  wire [2:0]  m_tuser,
    input  wire        m_tlast
);

    // Only defined status codes leave the block.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser <= csw_pkg::ST_WOKEN))
        else $error("undefined result status");

    // Results that name no thread carry a zero thread field.
    a_tid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == csw_pkg::ST_GRANTED || m_tuser == csw_pkg::ST_FULL ||
                     m_tuser == csw_pkg::ST_RELEASED || m_tuser == csw_pkg::ST_IGNORED)
        |-> (m_tdata[2:0] == 3'd0))
        else $error("thread field set on a result that names no thread");

    // While a request still has results to come, no new request is taken.
    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a wake run");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("stalled result beat changed");

endmodule

bind counting_semaphore_wait_list csw_checker u_csw_checker (.*);

`default_nettype wire

[tb/semaphore_checker.sv]
// Checker for the counting semaphore: predicts every result beat and compares it.
`default_nettype none

module semaphore_checker #(
    parameter int unsigned NUM_THREADS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Request stream, watched only.
    input  wire                              s_tvalid,
    input  wire                              s_tready,
    input  wire  [7:0]                       s_tdata,   // [2:0] thread_id, [7:3] zero
    input  wire                              s_tuser,   // [0] command
    // Result stream, watched only.
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    input  wire  [15:0]                      m_tdata,   // [2:0] woken_thread, [10:3] count_now
    input  wire  [2:0]                       m_tuser,   // [2:0] status
    input  wire                              m_tlast,
    // Configuration writes, watched only.
    input  wire                              i_cfg_we,
    input  wire  [csw_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  wire  [csw_pkg::CountW-1:0]       i_cfg_data,
    // Verdict inputs for the testbench top.
    output int                               o_mismatches,
    output int                               o_backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        csw_pkg::t_status status;
        csw_pkg::t_tid    tid;
        csw_pkg::t_count  count_now;
        logic             last;
    } t_sem_result;

    // Results predicted but not yet seen on the result stream, oldest first.
    t_sem_result expected_results[$];

    // Shadow copy of the semaphore: registers, count and the stack of waiters.
    csw_pkg::t_count sem_max;
    csw_pkg::t_count sem_init;
    csw_pkg::t_count sem_count;
    csw_pkg::t_tid   waiters[NUM_THREADS];
    int              waiter_depth;

    int mismatch_count = 0;
    int backlog_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_backlog    = backlog_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t ns] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // A write to either register, and reset, reload the count and empty the wait list.
    task automatic reload_setup();
        sem_count    = (sem_init > sem_max) ? sem_max : sem_init;
        waiter_depth = 0;
    endtask

    task automatic apply_register_write(input logic [csw_pkg::CfgIdxW-1:0] idx,
                                        input csw_pkg::t_count value);
        if (idx == csw_pkg::REG_MAX_COUNT) begin
            sem_max = (value == '0) ? csw_pkg::t_count'(1) : value;
            reload_setup();
        end else if (idx == csw_pkg::REG_INITIAL_COUNT) begin
            sem_init = value;
            reload_setup();
        end
    endtask

    task automatic push_result(input csw_pkg::t_status st, input csw_pkg::t_tid tid,
                               input logic fin);
        t_sem_result r;
        r.status    = st;
        r.tid       = tid;
        r.count_now = sem_count;
        r.last      = fin;
        expected_results.push_back(r);
    endtask

    // Work out every result that one request causes and update the shadow state.
    task automatic predict_request(input logic cmd, input csw_pkg::t_tid tid);
        if (cmd == csw_pkg::CMD_ACQUIRE) begin
            if (sem_count != '0) begin
                sem_count--;
                push_result(csw_pkg::ST_GRANTED, '0, 1'b1);
            end else if (waiter_depth >= NUM_THREADS) begin
                push_result(csw_pkg::ST_FULL, '0, 1'b1);
            end else begin
                waiters[waiter_depth] = tid;
                waiter_depth++;
                push_result(csw_pkg::ST_BLOCKED, tid, 1'b1);
            end
        end else if (sem_count >= sem_max) begin
            push_result(csw_pkg::ST_IGNORED, '0, 1'b1);
        end else begin
            sem_count++;
            push_result(csw_pkg::ST_RELEASED, '0, waiter_depth == 0);
            // Wake every waiter, most recently blocked first.
            while (waiter_depth > 0) begin
                waiter_depth--;
                push_result(csw_pkg::ST_WOKEN, waiters[waiter_depth], waiter_depth == 0);
            end
        end
    endtask

    // Results are checked before the request of the same edge is predicted,
    // since a result beat can never belong to a request taken at that edge.
    always @(posedge i_clk) begin
        t_sem_result got;
        t_sem_result want;
        if (!i_rst_n) begin
            sem_max  = csw_pkg::t_count'(1);
            sem_init = '0;
            reload_setup();
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status    = m_tuser;
                got.tid       = m_tdata[csw_pkg::TidW-1:0];
                got.count_now = m_tdata[csw_pkg::TidW +: csw_pkg::CountW];
                got.last      = m_tlast;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected beat status %0d tid %0d count %0d last %0d",
                        got.status, got.tid, got.count_now, got.last));
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.tid !== want.tid ||
                        got.count_now !== want.count_now || got.last !== want.last) begin
                        report_mismatch($sformatf(
                            "got status %0d tid %0d count %0d last %0d, want %0d/%0d/%0d/%0d",
                            got.status, got.tid, got.count_now, got.last,
                            want.status, want.tid, want.count_now, want.last));
                    end
                end
            end
            if (i_cfg_we) begin
                apply_register_write(i_cfg_idx, i_cfg_data);
            end
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata[csw_pkg::TidW-1:0]);
            end
        end
        backlog_count = expected_results.size();
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench top for the counting semaphore: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NumThreads = 8;
    localparam int unsigned GapPct     = 12;
    localparam int unsigned PhaseItems = 30;
    localparam int unsigned RandPhases = 7;
    localparam int unsigned TailCycles = 20;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [csw_pkg::CfgIdxW-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [csw_pkg::CfgIdxW-1:0] REG_SPARE_HI = 2'd3;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [7:0]                   s_tdata;    // [2:0] thread_id, [7:3] zero
    logic                         s_tuser;    // [0] command
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [15:0]                  m_tdata;    // [2:0] woken_thread, [10:3] count_now
    logic [2:0]                   m_tuser;    // [2:0] status
    logic                         m_tlast;
    logic                         i_cfg_we;
    logic [csw_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [csw_pkg::CountW-1:0]   i_cfg_data;

    int mismatches;
    int result_backlog;

    // While set, neither side inserts idle cycles.
    logic steady_flow = 1'b0;

    counting_semaphore_wait_list #(
        .NUM_THREADS(NumThreads)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    semaphore_checker #(
        .NUM_THREADS(NumThreads)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_backlog    (result_backlog)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side stalls at random, except during the steady stretch.
    always @(posedge i_clk) begin
        m_tready <= steady_flow || ($urandom_range(99) >= GapPct);
    end

    // Send one request beat; tvalid stays high afterwards unless a gap follows.
    task automatic send_request(input logic cmd, input csw_pkg::t_tid tid);
        if (!steady_flow) begin
            while ($urandom_range(99) < GapPct) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, tid};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (result_backlog != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [csw_pkg::CfgIdxW-1:0] idx,
                                  input csw_pkg::t_count value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random phase: a fresh setting, then a burst of mixed requests.
    task automatic run_random_phase(input int unsigned n_items);
        csw_pkg::t_count max_val;
        csw_pkg::t_count init_val;
        int unsigned     acquire_pct;
        wait_until_idle();
        case ($urandom_range(5))
            0:       max_val = '0;
            1:       max_val = csw_pkg::t_count'(1);
            2:       max_val = csw_pkg::t_count'($urandom_range(4, 2));
            3:       max_val = csw_pkg::t_count'($urandom_range(254, 5));
            4:       max_val = csw_pkg::t_count'(255);
            default: max_val = csw_pkg::t_count'($urandom_range(3, 1));
        endcase
        case ($urandom_range(2))
            0:       init_val = '0;
            1:       init_val = max_val;
            default: init_val = csw_pkg::t_count'($urandom_range(255));
        endcase
        case ($urandom_range(3))
            0: begin
                write_register(csw_pkg::REG_MAX_COUNT, max_val);
                write_register(csw_pkg::REG_INITIAL_COUNT, init_val);
            end
            1: begin
                write_register(csw_pkg::REG_INITIAL_COUNT, init_val);
                write_register(csw_pkg::REG_MAX_COUNT, max_val);
            end
            2:       write_register(csw_pkg::REG_MAX_COUNT, max_val);
            default: write_register(csw_pkg::REG_INITIAL_COUNT, init_val);
        endcase
        if ($urandom_range(3) == 0) begin
            write_register($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                           csw_pkg::t_count'($urandom));
        end
        acquire_pct = $urandom_range(80, 40);
        for (int unsigned i = 0; i < n_items; i++) begin
            send_request(($urandom_range(99) < acquire_pct) ?
                             csw_pkg::CMD_ACQUIRE : csw_pkg::CMD_RELEASE,
                         csw_pkg::t_tid'($urandom_range(NumThreads - 1)));
        end
    endtask

    initial begin
        csw_pkg::t_tid fill_order[NumThreads] =
            '{3'd3, 3'd7, 3'd0, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2};

        i_rst_n    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= csw_pkg::CMD_ACQUIRE;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= csw_pkg::REG_MAX_COUNT;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting (maximum one, count zero): fill the list, with one
        // thread blocking twice, overflow it, then wake all eight at once.
        foreach (fill_order[i]) send_request(csw_pkg::CMD_ACQUIRE, fill_order[i]);
        send_request(csw_pkg::CMD_ACQUIRE, 3'd4);
        send_request(csw_pkg::CMD_RELEASE, 3'd0);
        send_request(csw_pkg::CMD_RELEASE, 3'd7);
        send_request(csw_pkg::CMD_ACQUIRE, 3'd0);
        send_request(csw_pkg::CMD_ACQUIRE, 3'd7);

        // Top of the count range; the write also drops the blocked thread.
        wait_until_idle();
        write_register(csw_pkg::REG_MAX_COUNT, 8'd255);
        write_register(csw_pkg::REG_INITIAL_COUNT, 8'd255);
        send_request(csw_pkg::CMD_RELEASE, 3'd0);
        send_request(csw_pkg::CMD_ACQUIRE, 3'd5);
        send_request(csw_pkg::CMD_RELEASE, 3'd2);

        // A zero maximum acts as one and clamps the initial count; writes to
        // unused indexes must leave the waiter in place.
        wait_until_idle();
        write_register(csw_pkg::REG_MAX_COUNT, 8'd0);
        send_request(csw_pkg::CMD_ACQUIRE, 3'd1);
        send_request(csw_pkg::CMD_ACQUIRE, 3'd6);
        wait_until_idle();
        write_register(REG_SPARE_LO, 8'hFF);
        write_register(REG_SPARE_HI, 8'h00);
        send_request(csw_pkg::CMD_RELEASE, 3'd4);

        // A write empties the list: the release then wakes nobody.
        wait_until_idle();
        write_register(csw_pkg::REG_INITIAL_COUNT, 8'd0);
        send_request(csw_pkg::CMD_ACQUIRE, 3'd1);
        wait_until_idle();
        write_register(csw_pkg::REG_MAX_COUNT, 8'd2);
        send_request(csw_pkg::CMD_RELEASE, 3'd3);

        // Random phases; one of them runs with no idle cycles on either side.
        for (int unsigned p = 0; p < RandPhases; p++) begin
            steady_flow <= (p == 3);
            run_random_phase(PhaseItems);
        end

        wait_until_idle();
        steady_flow <= 1'b0;
        repeat (TailCycles) @(posedge i_clk);
        if (mismatches == 0 && result_backlog == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run time limit, far above the slowest correct run.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
